// ===== sv/vector_distance_topk_select_defines.svh =====
// Assertion macros shared by the RTL of the distance and top-k select block.
`ifndef VECTOR_DISTANCE_TOPK_SELECT_DEFINES_SVH
`define VECTOR_DISTANCE_TOPK_SELECT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VDTK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VDTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vdtk_pkg.sv =====
`timescale 1ns / 1ps
package vdtk_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int MAX_DIM    = 1024;
  localparam int ELEM_BITS  = 16;
  localparam int SCORE_BITS = 48;
  localparam int ID_BITS    = 31;
  localparam int KEEP_BITS  = 5;
  localparam int CAP_BITS   = $clog2(MAX_KEEP + 1);
  localparam int DIFF_BITS  = ELEM_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = KEEP_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_METRIC = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP   = CFG_IDX_BITS'(1);

  localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(10);

  // One kept candidate
  typedef struct packed {
    logic                         valid;
    logic signed [SCORE_BITS-1:0] score;
    logic [ID_BITS-1:0]           id;
  } entry_t;

  // Finished candidate offered to the list
  typedef struct packed {
    logic                         valid;
    logic                         qend;
    logic signed [SCORE_BITS-1:0] score;
    logic [ID_BITS-1:0]           id;
  } offer_t;

  // Broadcast to every list cell
  typedef struct packed {
    logic                         apply;
    logic                         dump;
    logic signed [SCORE_BITS-1:0] score;
    logic [ID_BITS-1:0]           id;
  } cell_ctl_t;

endpackage

// ===== sv/vdtk_mac.sv =====
`timescale 1ns / 1ps
module vdtk_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic                                  stall,
  input  logic                                  metric_is_inner,
  input  logic signed [vdtk_pkg::ELEM_BITS-1:0] query_elem,
  input  logic signed [vdtk_pkg::ELEM_BITS-1:0] cand_elem,
  input  logic [vdtk_pkg::ID_BITS-1:0]          cand_id,
  input  logic                                  vec_end,
  input  logic                                  query_end,
  output vdtk_pkg::offer_t                      off
);

  localparam int SUM_BITS = vdtk_pkg::SCORE_BITS + 1;

  logic signed [vdtk_pkg::DIFF_BITS-1:0] q_ext, c_ext, diff, mul_a, mul_b;
  logic signed [vdtk_pkg::PROD_BITS-1:0] prod;

  logic                                  s1_valid;
  logic signed [vdtk_pkg::PROD_BITS-1:0] s1_prod;
  logic                                  s1_neg;
  logic [vdtk_pkg::ID_BITS-1:0]          s1_id;
  logic                                  s1_vend;
  logic                                  s1_qend;

  logic signed [vdtk_pkg::SCORE_BITS-1:0] acc;
  logic signed [SUM_BITS-1:0]             term, sum;
  logic signed [vdtk_pkg::SCORE_BITS-1:0] sat;
  logic                                   s1_end;

  // Operand select: difference squared, or plain product to be negated
  always_comb begin
    q_ext = vdtk_pkg::DIFF_BITS'(query_elem);
    c_ext = vdtk_pkg::DIFF_BITS'(cand_elem);
    diff  = q_ext - c_ext;
    mul_a = metric_is_inner ? q_ext : diff;
    mul_b = metric_is_inner ? c_ext : diff;
    prod  = mul_a * mul_b;
  end

  // Accumulate with saturation at the score limits
  always_comb begin
    term = SUM_BITS'(s1_prod);
    if (s1_neg) begin
      term = -term;
    end
    sum = SUM_BITS'(acc) + term;
    if (sum[SUM_BITS-1] != sum[SUM_BITS-2]) begin
      sat = sum[SUM_BITS-1] ? {1'b1, {(vdtk_pkg::SCORE_BITS-1){1'b0}}}
                            : {1'b0, {(vdtk_pkg::SCORE_BITS-1){1'b1}}};
    end else begin
      sat = sum[vdtk_pkg::SCORE_BITS-1:0];
    end
    s1_end = s1_vend || s1_qend;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      off.valid <= 1'b0;
      acc       <= '0;
    end else if (!stall) begin
      s1_valid  <= take;
      off.valid <= s1_valid && s1_end;
      if (s1_valid) begin
        acc <= s1_end ? '0 : sat;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_prod   <= prod;
      s1_neg    <= metric_is_inner;
      s1_id     <= cand_id;
      s1_vend   <= vec_end;
      s1_qend   <= query_end;
      off.qend  <= s1_qend;
      off.score <= sat;
      off.id    <= s1_id;
    end
  end

endmodule

// ===== sv/vdtk_cell.sv =====
`timescale 1ns / 1ps
module vdtk_cell (
  input  logic                clk,
  input  logic                rst,
  input  vdtk_pkg::cell_ctl_t ctl,
  input  logic                in_range,
  input  vdtk_pkg::entry_t    left_ent,
  input  logic                left_keep,
  output vdtk_pkg::entry_t    ent,
  output logic                keep,
  output vdtk_pkg::entry_t    ent_next
);

  vdtk_pkg::entry_t nxt;

  // Stay, take the new score, or take the left neighbour's entry
  always_comb begin
    keep = ent.valid && (ent.score <= ctl.score);
    if (!left_keep) begin
      nxt = left_ent;
    end else if (keep) begin
      nxt = ent;
    end else begin
      nxt.valid = 1'b1;
      nxt.score = ctl.score;
      nxt.id    = ctl.id;
    end
    nxt.valid = nxt.valid && in_range;
    ent_next  = nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.apply) begin
      ent.valid <= nxt.valid && !ctl.dump;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      ent.score <= nxt.score;
      ent.id    <= nxt.id;
    end
  end

endmodule

// ===== sv/vdtk_drain_cell.sv =====
`timescale 1ns / 1ps
module vdtk_drain_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  vdtk_pkg::entry_t load_ent,
  input  logic             shift,
  input  vdtk_pkg::entry_t right_ent,
  output vdtk_pkg::entry_t ent
);

  // Parallel load of the finished list, else shift towards the output
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (load) begin
      ent.valid <= load_ent.valid;
    end else if (shift) begin
      ent.valid <= right_ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent.score <= load_ent.score;
      ent.id    <= load_ent.id;
    end else if (shift) begin
      ent.score <= right_ent.score;
      ent.id    <= right_ent.id;
    end
  end

endmodule

// ===== sv/vector_distance_topk_select.sv =====
// Streaming k-nearest-neighbour scoring with top-k selection.
// Input channel (in_valid/in_ready): one query/candidate element pair per
// transfer, with the candidate id and end-of-vector / end-of-query marks.
// Elements are taken one per cycle while in_ready is high; a candidate's score
// passes the element stage and the offer register after its last element and
// is then offered to a sorted row of cells. At end of query the updated list
// is loaded in parallel into an output row and streamed out (out_valid/
// out_ready) in ascending score order, one result per cycle while out_ready is
// high, is_last on the final one; the list is cleared in the same step.
// Input is only held back while an end-of-query candidate waits for the
// output row to finish draining the previous query's results; a stalled
// receiver therefore stalls the input only at the next end of query.
// Configuration (cfg_we/cfg_index/cfg_data) takes effect at once; the user must
// write it only while the block is idle (the block does not enforce this):
// index 0 selects the metric, index 1 the number of entries kept (0 acts as 1,
// above the cell count as the count). Synchronous reset empties both rows and the
// accumulator and restores the register defaults: squared L2 distance, ten entries kept.
`timescale 1ns / 1ps
`include "vector_distance_topk_select_defines.svh"
module vector_distance_topk_select (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [vdtk_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [vdtk_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [vdtk_pkg::ELEM_BITS-1:0]     query_elem,
  input  logic signed [vdtk_pkg::ELEM_BITS-1:0]     cand_elem,
  input  logic [vdtk_pkg::ID_BITS-1:0]              cand_id,
  input  logic                                      vec_end,
  input  logic                                      query_end,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [vdtk_pkg::ID_BITS-1:0]              best_id,
  output logic signed [vdtk_pkg::SCORE_BITS-1:0]    best_score,
  output logic                                      is_last
);

  localparam int N = vdtk_pkg::MAX_KEEP;

  logic                              metric_is_inner;
  logic [vdtk_pkg::KEEP_BITS-1:0]    keep_count;
  logic [vdtk_pkg::CAP_BITS-1:0]     cap;

  vdtk_pkg::offer_t                  off;
  vdtk_pkg::cell_ctl_t               ctl;
  logic                              stall;
  logic                              drain_free;
  logic                              shift;

  vdtk_pkg::entry_t                  kent [N];
  vdtk_pkg::entry_t                  knext [N];
  vdtk_pkg::entry_t                  kleft [N];
  logic                              kkeep [N];
  logic                              kleft_keep [N];
  logic                              in_range [N];

  vdtk_pkg::entry_t                  dent [N];
  vdtk_pkg::entry_t                  dright [N];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_is_inner <= 1'b0;
      keep_count      <= vdtk_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vdtk_pkg::REG_METRIC: metric_is_inner <= cfg_data[0];
        vdtk_pkg::REG_KEEP:   keep_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective capacity
  always_comb begin
    if (keep_count == '0) begin
      cap = vdtk_pkg::CAP_BITS'(1);
    end else if (32'(keep_count) > N) begin
      cap = vdtk_pkg::CAP_BITS'(N);
    end else begin
      cap = vdtk_pkg::CAP_BITS'(keep_count);
    end
  end

  // Flow control: an end-of-query offer waits for the output row
  always_comb begin
    shift      = out_valid && out_ready;
    drain_free = !dent[0].valid || (out_ready && is_last);
    stall      = off.valid && off.qend && !drain_free;
    in_ready   = !stall;
    ctl.apply  = off.valid && !stall;
    ctl.dump   = off.valid && !stall && off.qend;
    ctl.score  = off.score;
    ctl.id     = off.id;
  end

  vdtk_mac u_mac (
    .clk             (clk),
    .rst             (rst),
    .take            (in_valid && in_ready),
    .stall           (stall),
    .metric_is_inner (metric_is_inner),
    .query_elem      (query_elem),
    .cand_elem       (cand_elem),
    .cand_id         (cand_id),
    .vec_end         (vec_end),
    .query_end       (query_end),
    .off             (off)
  );

  // Sorted row of kept entries and the output row behind it
  for (genvar i = 0; i < N; i++) begin : g_row
    if (i == 0) begin : g_head
      assign kleft[i]      = '0;
      assign kleft_keep[i] = 1'b1;
    end else begin : g_body
      assign kleft[i]      = kent[i-1];
      assign kleft_keep[i] = kkeep[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign dright[i] = '0;
    end else begin : g_mid
      assign dright[i] = dent[i+1];
    end
    assign in_range[i] = vdtk_pkg::CAP_BITS'(i) < cap;

    vdtk_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .in_range  (in_range[i]),
      .left_ent  (kleft[i]),
      .left_keep (kleft_keep[i]),
      .ent       (kent[i]),
      .keep      (kkeep[i]),
      .ent_next  (knext[i])
    );

    vdtk_drain_cell u_drain (
      .clk       (clk),
      .rst       (rst),
      .load      (ctl.dump),
      .load_ent  (knext[i]),
      .shift     (shift),
      .right_ent (dright[i]),
      .ent       (dent[i])
    );
  end

  // Result port straight from the head of the output row
  assign out_valid  = dent[0].valid;
  assign best_id    = dent[0].id;
  assign best_score = dent[0].score;
  assign is_last    = !dright[0].valid;

  // Checks
  `VDTK_ASSERT_NEXT(a_dump_gives_result, ctl.dump, out_valid,
                    "end of query produced no result")
  `VDTK_ASSERT_NEXT(a_last_empties_row, shift && is_last && !ctl.dump, !out_valid,
                    "output row not empty after last result")
  for (genvar j = 1; j < N; j++) begin : g_chk
    `VDTK_ASSERT_NOW(a_prefix, kent[j].valid, kent[j-1].valid,
                     "kept entries not a contiguous prefix")
    `VDTK_ASSERT_NOW(a_sorted, kent[j].valid, kent[j-1].score <= kent[j].score,
                     "kept entries out of order")
  end

endmodule
